// ===== hdl/dsg_pkg.sv =====
// ----------------------------------------------------------------------------
// dsg_pkg
// Shared types, constants and the quarter-wave sine table of the decaying
// sine generator.
// ----------------------------------------------------------------------------
`default_nettype none

package dsg_pkg;

   localparam int SINE_TABLE_BITS = 8;
   localparam int COUNT_BITS      = 24;

   localparam int TBL_N      = 1 << SINE_TABLE_BITS;
   localparam int PHASE_BITS = 32;
   localparam int AMP_BITS   = 15;
   localparam int ENV_BITS   = 31;
   localparam int MAG_BITS   = 15;
   localparam int SAMPLE_BITS = 16;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_INDEX_BITS = 2;
   localparam int COUNT_FIELD_BITS = 24;
   localparam int PROD_BITS  = 61;

   localparam logic [ENV_BITS-1:0] ENV_ONE = '1;
   localparam logic [MAG_BITS-1:0] MAG_MAX = '1;
   localparam logic [31:0]         HALFPI_Q30 = 32'd1686629713;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PHASE_INC  = 2'd0,
      CSR_AMPLITUDE  = 2'd1,
      CSR_DECAY      = 2'd2,
      CSR_COUNT      = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCALE,
      ST_ENVELOPE,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      MUL_MAG_AMP,
      MUL_SCALE_ENV,
      MUL_ENV_DECAY
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      mul_sel_type mul_sel;
      logic        finish;
   } dsg_cmd_type;

   typedef struct packed {
      logic out_stall;
   } dsg_status_type;

   typedef logic [MAG_BITS-1:0] sine_tbl_type [TBL_N];

   // Degree-15 Taylor series in Q2.30, evaluated at elaboration only.
   function automatic logic [MAG_BITS-1:0] sine_entry(input int unsigned k);
      logic [63:0] x;
      logic [63:0] term;
      logic [63:0] sum;
      x    = (64'(HALFPI_Q30) * 64'(k)) >> SINE_TABLE_BITS;
      term = x;
      sum  = x;
      term = (((term * x) >> 30) * x) >> 30;
      term = term / 64'd6;
      sum  = sum - term;
      term = (((term * x) >> 30) * x) >> 30;
      term = term / 64'd20;
      sum  = sum + term;
      term = (((term * x) >> 30) * x) >> 30;
      term = term / 64'd42;
      sum  = sum - term;
      term = (((term * x) >> 30) * x) >> 30;
      term = term / 64'd72;
      sum  = sum + term;
      term = (((term * x) >> 30) * x) >> 30;
      term = term / 64'd110;
      sum  = sum - term;
      term = (((term * x) >> 30) * x) >> 30;
      term = term / 64'd156;
      sum  = sum + term;
      term = (((term * x) >> 30) * x) >> 30;
      term = term / 64'd210;
      sum  = sum - term;
      sum  = (sum + 64'd16384) >> 15;
      if (sum > 64'd32767) begin
         sum = 64'd32767;
      end
      return sum[MAG_BITS-1:0];
   endfunction

   function automatic sine_tbl_type build_sine_table();
      sine_tbl_type tbl;
      for (int k = 0; k < TBL_N; k++) begin
         tbl[k] = sine_entry(k);
      end
      return tbl;
   endfunction

   localparam sine_tbl_type SINE_TABLE = build_sine_table();

endpackage

`default_nettype wire

// ===== hdl/decaying_sine_generator.sv =====
// Sequence: a request is looked up as it is accepted, then passes the scale,
//   envelope and finish states; the response register loads once it is free.
// Samples: no new request is taken until the last sample has finished; the
//   three products share the single 32x32 multiplier after the lookup.
// Reset: synchronous; clears the note state (phase, index, peak, envelope at
//   one), resets the configuration and clears the response valid flag.
// ----------------------------------------------------------------------------
// decaying_sine_generator
// Exponentially decaying sine oscillator: one Q1.15 sample per request.
// ----------------------------------------------------------------------------
`default_nettype none

module decaying_sine_generator (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     csr_we,
   input  wire  [dsg_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  wire  [dsg_pkg::CSR_DATA_BITS-1:0]       csr_wdata,
   input  wire                                     req_valid,
   output logic                                    req_ready,
   input  wire                                     req_restart,
   output logic                                    rsp_valid,
   input  wire                                     rsp_ready,
   output logic signed [dsg_pkg::SAMPLE_BITS-1:0]  rsp_sample,
   output logic                                    rsp_last,
   output logic [dsg_pkg::MAG_BITS-1:0]            rsp_peak,
   output logic                                    rsp_finished
);

   dsg_pkg::dsg_cmd_type    cmd;
   dsg_pkg::dsg_status_type status;

   dsg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dsg_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_restart  (req_restart),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_sample   (rsp_sample),
      .rsp_last     (rsp_last),
      .rsp_peak     (rsp_peak),
      .rsp_finished (rsp_finished)
   );

endmodule

`default_nettype wire

// ===== hdl/dsg_ctrl.sv =====
// ----------------------------------------------------------------------------
// dsg_ctrl
// Sequencer for one sample: table lookup, two scaling products and the
// envelope update on the shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module dsg_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  dsg_pkg::dsg_status_type status,
   output dsg_pkg::dsg_cmd_type    cmd
);

   dsg_pkg::state_type state_ff;
   dsg_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dsg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dsg_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = dsg_pkg::ST_SCALE;
            end
         end
         dsg_pkg::ST_SCALE:    state_in = dsg_pkg::ST_ENVELOPE;
         dsg_pkg::ST_ENVELOPE: state_in = dsg_pkg::ST_FINISH;
         dsg_pkg::ST_FINISH: begin
            if (!status.out_stall) begin
               state_in = dsg_pkg::ST_IDLE;
            end
         end
         default: state_in = dsg_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd.load    = 1'b0;
      cmd.mul_sel = dsg_pkg::MUL_MAG_AMP;
      cmd.finish  = 1'b0;
      case (state_ff)
         dsg_pkg::ST_IDLE: begin
            // take no request while reset is held
            req_ready = !reset;
            cmd.load  = req_valid && !reset;
         end
         dsg_pkg::ST_SCALE: begin
            cmd.mul_sel = dsg_pkg::MUL_MAG_AMP;
         end
         dsg_pkg::ST_ENVELOPE: begin
            cmd.mul_sel = dsg_pkg::MUL_SCALE_ENV;
         end
         dsg_pkg::ST_FINISH: begin
            cmd.mul_sel = dsg_pkg::MUL_ENV_DECAY;
            cmd.finish  = !status.out_stall;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   a_finish_returns_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (state_ff == dsg_pkg::ST_IDLE))
      else $error("sequencer did not return to idle after finishing a sample");

endmodule

`default_nettype wire

// ===== hdl/dsg_datapath.sv =====
// ----------------------------------------------------------------------------
// dsg_datapath
// Configuration registers, oscillator state, sine lookup, shared multiplier
// and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module dsg_datapath (
   input  wire                                          clock,
   input  wire                                          reset,
   input  wire                                          csr_we,
   input  wire  [dsg_pkg::CSR_INDEX_BITS-1:0]           csr_index,
   input  wire  [dsg_pkg::CSR_DATA_BITS-1:0]            csr_wdata,
   input  wire                                          req_restart,
   input  dsg_pkg::dsg_cmd_type                         cmd,
   output dsg_pkg::dsg_status_type                      status,
   output logic                                         rsp_valid,
   input  wire                                          rsp_ready,
   output logic signed [dsg_pkg::SAMPLE_BITS-1:0]       rsp_sample,
   output logic                                         rsp_last,
   output logic [dsg_pkg::MAG_BITS-1:0]                 rsp_peak,
   output logic                                         rsp_finished
);

   localparam int TB = dsg_pkg::SINE_TABLE_BITS;
   localparam int CB = dsg_pkg::COUNT_BITS;

   // configuration
   logic [dsg_pkg::PHASE_BITS-1:0] phase_inc_ff;
   logic [dsg_pkg::AMP_BITS-1:0]   amplitude_ff;
   logic [dsg_pkg::ENV_BITS-1:0]   decay_ff;
   logic [CB-1:0]                  count_ff;

   // oscillator state
   logic [dsg_pkg::PHASE_BITS-1:0] phase_ff, phase_in;
   logic [dsg_pkg::ENV_BITS-1:0]   envelope_ff, envelope_in;
   logic [CB-1:0]                  index_ff, index_in;
   logic [dsg_pkg::MAG_BITS-1:0]   peak_ff, peak_in;

   // per-sample work registers
   logic [dsg_pkg::MAG_BITS-1:0]   mag_ff, mag_in;
   logic                           neg_ff, neg_in;
   logic                           done_ff, done_in;
   logic [dsg_pkg::PROD_BITS-1:0]  prod_ff, prod_in;

   // response register
   logic                                    rsp_valid_ff;
   logic signed [dsg_pkg::SAMPLE_BITS-1:0]  rsp_sample_ff, rsp_sample_in;
   logic                                    rsp_last_ff, rsp_last_in;
   logic [dsg_pkg::MAG_BITS-1:0]            rsp_peak_ff, rsp_peak_in;
   logic                                    rsp_finished_ff, rsp_finished_in;

   logic [dsg_pkg::PHASE_BITS-1:0] phase_eff;
   logic [CB-1:0]                  index_eff;
   logic [TB+1:0]                  full_idx;
   logic [TB-1:0]                  tbl_r;
   logic [TB-1:0]                  tbl_idx;
   logic [31:0]                    mult_a, mult_b;
   logic [63:0]                    mult_p;
   logic [dsg_pkg::PROD_BITS:0]    round_sum;
   logic [dsg_pkg::SAMPLE_BITS-1:0] rounded;
   logic [dsg_pkg::MAG_BITS-1:0]   mag_out;
   logic [CB:0]                    index_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_inc_ff <= '0;
         amplitude_ff <= '0;
         decay_ff     <= dsg_pkg::ENV_ONE;
         count_ff     <= '0;
      end else if (csr_we) begin
         case (csr_index)
            dsg_pkg::CSR_PHASE_INC: phase_inc_ff <= csr_wdata;
            dsg_pkg::CSR_AMPLITUDE: amplitude_ff <= csr_wdata[dsg_pkg::AMP_BITS-1:0];
            dsg_pkg::CSR_DECAY:     decay_ff     <= csr_wdata[dsg_pkg::ENV_BITS-1:0];
            dsg_pkg::CSR_COUNT:
               count_ff <= CB'(csr_wdata[dsg_pkg::COUNT_FIELD_BITS-1:0]);
            default: ;
         endcase
      end
   end

   // restart takes effect before this request's lookup
   assign phase_eff = req_restart ? '0 : phase_ff;
   assign index_eff = req_restart ? '0 : index_ff;

   assign full_idx = phase_eff[dsg_pkg::PHASE_BITS-1 -: TB+2];
   assign tbl_r    = full_idx[TB-1:0];
   assign tbl_idx  = full_idx[TB] ? (TB'(0) - tbl_r) : tbl_r;

   always_comb begin
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      done_in = done_ff;
      if (cmd.load) begin
         if (full_idx[TB] && (tbl_r == '0)) begin
            mag_in = dsg_pkg::MAG_MAX;
         end else begin
            mag_in = dsg_pkg::SINE_TABLE[tbl_idx];
         end
         neg_in  = full_idx[TB+1];
         done_in = (index_eff >= count_ff);
      end
   end

   // shared multiplier
   always_comb begin
      case (cmd.mul_sel)
         dsg_pkg::MUL_MAG_AMP: begin
            mult_a = 32'(mag_ff);
            mult_b = 32'(amplitude_ff);
         end
         dsg_pkg::MUL_SCALE_ENV: begin
            mult_a = prod_ff[31:0];
            mult_b = 32'(envelope_ff);
         end
         dsg_pkg::MUL_ENV_DECAY: begin
            mult_a = 32'(envelope_ff);
            mult_b = 32'(decay_ff);
         end
         default: begin
            mult_a = '0;
            mult_b = '0;
         end
      endcase
   end

   assign mult_p  = mult_a * mult_b;
   // hold the scaled sample while the envelope product is on the multiplier
   assign prod_in = (cmd.mul_sel == dsg_pkg::MUL_ENV_DECAY) ? prod_ff
                                                            : mult_p[dsg_pkg::PROD_BITS-1:0];

   assign round_sum = {1'b0, prod_ff} + ((dsg_pkg::PROD_BITS+1)'(1) << 45);
   assign rounded   = round_sum[dsg_pkg::PROD_BITS -: dsg_pkg::SAMPLE_BITS];
   assign mag_out   = rounded[dsg_pkg::SAMPLE_BITS-1] ? dsg_pkg::MAG_MAX
                                                      : rounded[dsg_pkg::MAG_BITS-1:0];
   assign index_next = {1'b0, index_ff} + (CB+1)'(1);

   always_comb begin
      phase_in        = phase_ff;
      envelope_in     = envelope_ff;
      index_in        = index_ff;
      peak_in         = peak_ff;
      rsp_sample_in   = rsp_sample_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_peak_in     = rsp_peak_ff;
      rsp_finished_in = rsp_finished_ff;
      if (cmd.load && req_restart) begin
         phase_in    = '0;
         envelope_in = dsg_pkg::ENV_ONE;
         index_in    = '0;
         peak_in     = '0;
      end
      if (cmd.finish) begin
         if (done_ff) begin
            rsp_sample_in   = '0;
            rsp_last_in     = 1'b0;
            rsp_peak_in     = peak_ff;
            rsp_finished_in = 1'b1;
         end else begin
            if (mag_out > peak_ff) begin
               peak_in = mag_out;
            end else begin
               peak_in = peak_ff;
            end
            rsp_sample_in   = neg_ff ? -$signed({1'b0, mag_out})
                                     : $signed({1'b0, mag_out});
            rsp_last_in     = (index_next == {1'b0, count_ff});
            rsp_peak_in     = peak_in;
            rsp_finished_in = 1'b0;
            envelope_in     = mult_p[dsg_pkg::ENV_BITS +: dsg_pkg::ENV_BITS];
            phase_in        = phase_ff + phase_inc_ff;
            index_in        = index_next[CB-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         envelope_ff  <= dsg_pkg::ENV_ONE;
         index_ff     <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         envelope_ff <= envelope_in;
         index_ff    <= index_in;
         peak_ff     <= peak_in;
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      mag_ff          <= mag_in;
      neg_ff          <= neg_in;
      done_ff         <= done_in;
      prod_ff         <= prod_in;
      rsp_sample_ff   <= rsp_sample_in;
      rsp_last_ff     <= rsp_last_in;
      rsp_peak_ff     <= rsp_peak_in;
      rsp_finished_ff <= rsp_finished_in;
   end

   // hold the finish step while an earlier response is still waiting
   assign status.out_stall = rsp_valid_ff && !rsp_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_sample   = rsp_sample_ff;
   assign rsp_last     = rsp_last_ff;
   assign rsp_peak     = rsp_peak_ff;
   assign rsp_finished = rsp_finished_ff;

   a_finished_is_silent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_finished_ff) |-> ((rsp_sample_ff == '0) && !rsp_last_ff))
      else $error("finished response carries a nonzero sample or last flag");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !(rsp_valid_ff && !rsp_ready))
      else $error("response register overwritten while still pending");

   a_peak_grows: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && req_restart) |=> (peak_ff >= $past(peak_ff)))
      else $error("peak magnitude dropped without a restart");

   a_peak_tracks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_finished_ff)
         |-> (rsp_peak_ff >= (rsp_sample_ff[dsg_pkg::SAMPLE_BITS-1]
                              ? dsg_pkg::MAG_BITS'(-rsp_sample_ff)
                              : rsp_sample_ff[dsg_pkg::MAG_BITS-1:0])))
      else $error("reported peak is below the sample magnitude");

endmodule

`default_nettype wire
